// File: rtl/core/first_fit_range_allocator_macros.svh
// Assertion macros used by the allocator module.
// Needs clk and arst_n in the scope that uses them.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFRA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffra assertion failed");

// next-cycle implication
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffra assertion failed");

`endif

// File: rtl/core/ffra_pkg.sv
// Shared types and constants of the first-fit range allocator.
// No dependencies.
package ffra_pkg;
	localparam int MAX_SLOTS  = 1024;
	localparam int MAX_RANGES = 512;
	localparam int ADDR_W     = $clog2(MAX_RANGES);
	localparam int IDX_W      = ADDR_W + 1;
	localparam int OFF_W      = 10;
	localparam int LEN_W      = 11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_TOTAL = 2'd1;
	localparam logic [1:0] ST_FRAG  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} tbl_req_t;

	typedef struct packed {
		logic [LEN_W-1:0] a;
		logic [LEN_W-1:0] b;
		logic             sub;
	} alu_op_t;

	typedef struct packed {
		logic [LEN_W:0] res;
		logic           lt;
		logic           eq;
	} alu_res_t;
endpackage

// File: rtl/core/ffra_alu.sv
// Shared add/subtract/compare unit of the allocator sequencer.
// Depends on ffra_pkg.
module ffra_alu (
	input  ffra_pkg::alu_op_t  op,
	output ffra_pkg::alu_res_t rs
);
	logic [ffra_pkg::LEN_W:0] ax, bx, r;

	always_comb begin
		ax = {1'b0, op.a};
		bx = {1'b0, op.b};
		r  = op.sub ? (ax - bx) : (ax + bx);
		rs.res = r;
		rs.lt  = op.sub & r[ffra_pkg::LEN_W];
		rs.eq  = (r == '0);
	end
endmodule

// File: rtl/core/ffra_table.sv
// Free-range table: one write port, one registered read port.
// Depends on ffra_pkg.
module ffra_table (
	input  logic               clk,
	input  ffra_pkg::tbl_req_t req,
	output ffra_pkg::entry_t   rdata
);
	ffra_pkg::entry_t mem [ffra_pkg::MAX_RANGES];
	ffra_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/core/first_fit_range_allocator.sv
// First-fit range allocator: sequencer over a sorted free-range table.
// Allocate and free scan the table one range read at a time; a free scan may run off the table end.
// Erase and insert shift table entries one at a time; a two-sided merge also erases an entry.
// Rejected requests finish early.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (arst_n low): heap_size 1024, one free range {0, 1024}.
`include "first_fit_range_allocator_macros.svh"
module first_fit_range_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [10:0] count,
	input  logic [9:0]  offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [9:0]  block_offset,
	output logic [10:0] free_total
);
	localparam int AW = ffra_pkg::ADDR_W;
	localparam int IW = ffra_pkg::IDX_W;
	localparam int LW = ffra_pkg::LEN_W;
	localparam int OW = ffra_pkg::OFF_W;

	localparam logic [4:0] S_INIT = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_ACHK = 5'd2;
	localparam logic [4:0] S_ARD  = 5'd3;
	localparam logic [4:0] S_ACMP = 5'd4;
	localparam logic [4:0] S_ABLK = 5'd5;
	localparam logic [4:0] S_ATOT = 5'd6;
	localparam logic [4:0] S_ERRD = 5'd7;
	localparam logic [4:0] S_ERWR = 5'd8;
	localparam logic [4:0] S_FEND = 5'd9;
	localparam logic [4:0] S_FCHK = 5'd10;
	localparam logic [4:0] S_FRD  = 5'd11;
	localparam logic [4:0] S_FCMP = 5'd12;
	localparam logic [4:0] S_LCHK = 5'd13;
	localparam logic [4:0] S_LCMP = 5'd14;
	localparam logic [4:0] S_RCHK = 5'd15;
	localparam logic [4:0] S_FACT = 5'd16;
	localparam logic [4:0] S_FJB  = 5'd17;
	localparam logic [4:0] S_INRD = 5'd18;
	localparam logic [4:0] S_INWR = 5'd19;
	localparam logic [4:0] S_FTOT = 5'd20;
	localparam logic [4:0] S_DONE = 5'd21;

	localparam logic [IW-1:0] IDX_ONE = IW'(1);
	localparam logic [IW-1:0] IDX_MAX = IW'(ffra_pkg::MAX_RANGES);
	localparam logic [LW-1:0] HEAP_MAX = LW'(ffra_pkg::MAX_SLOTS);

	logic [4:0]          state_q;
	logic                kind_q;
	logic [LW-1:0]       count_q, heap_q, free_q, end_q, tmp_q;
	logic [OW-1:0]       off_q, blk_q;
	logic [IW-1:0]       cnt_q, idx_q, k_q;
	ffra_pkg::entry_t    left_q, right_q, ent_q;
	logic                has_left_q, has_right_q, jl_q, jr_q;
	logic [1:0]          status_q;
	logic                out_valid_q;
	logic [1:0]          o_status_q;
	logic [OW-1:0]       o_blk_q;
	logic [LW-1:0]       o_free_q;

	ffra_pkg::tbl_req_t  req;
	ffra_pkg::entry_t    rdata;
	ffra_pkg::alu_op_t   op;
	ffra_pkg::alu_res_t  rs;
	logic [IW-1:0]       idx_m1, k_p1, k_m1;
	logic [LW-1:0]       cfg_clamp;

	ffra_table u_table (.clk(clk), .req(req), .rdata(rdata));
	ffra_alu   u_alu   (.op(op), .rs(rs));

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign block_offset = o_blk_q;
	assign free_total   = o_free_q;

	assign idx_m1 = idx_q - IDX_ONE;
	assign k_p1   = k_q + IDX_ONE;
	assign k_m1   = k_q - IDX_ONE;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamp = LW'(1);
		end else if (cfg_data > HEAP_MAX) begin
			cfg_clamp = HEAP_MAX;
		end else begin
			cfg_clamp = cfg_data;
		end
	end

	// operand select for the shared unit
	always_comb begin
		op = '0;
		unique case (state_q)
			S_ACHK: begin op.a = free_q; op.b = count_q; op.sub = 1'b1; end
			S_ACMP: begin op.a = rdata.length; op.b = count_q; op.sub = 1'b1; end
			S_ABLK: begin op.a = LW'(ent_q.start); op.b = tmp_q; end
			S_ATOT: begin op.a = free_q; op.b = count_q; op.sub = 1'b1; end
			S_FEND: begin op.a = LW'(off_q); op.b = count_q; end
			S_FCHK: begin op.a = heap_q; op.b = end_q; op.sub = 1'b1; end
			S_FCMP: begin op.a = LW'(off_q); op.b = LW'(rdata.start); op.sub = 1'b1; end
			S_LCHK: begin op.a = LW'(left_q.start); op.b = left_q.length; end
			S_LCMP: begin op.a = LW'(off_q); op.b = tmp_q; op.sub = 1'b1; end
			S_RCHK: begin op.a = LW'(right_q.start); op.b = end_q; op.sub = 1'b1; end
			S_FACT: begin
				op.a = jl_q ? left_q.length : right_q.length;
				op.b = count_q;
			end
			S_FJB:  begin op.a = tmp_q; op.b = right_q.length; end
			S_FTOT: begin op.a = free_q; op.b = count_q; end
			default: op = '0;
		endcase
	end

	// table port
	always_comb begin
		req = '0;
		unique case (state_q)
			S_INIT: begin
				req.we = 1'b1;
				req.wdata.length = heap_q;
			end
			S_ARD:  req.raddr = idx_q[AW-1:0];
			S_FRD:  req.raddr = idx_q[AW-1:0];
			S_ABLK: begin
				req.we    = (tmp_q != '0);
				req.waddr = idx_q[AW-1:0];
				req.wdata = '{start: ent_q.start, length: tmp_q};
			end
			S_ERRD: req.raddr = k_p1[AW-1:0];
			S_ERWR: begin
				req.we    = 1'b1;
				req.waddr = k_q[AW-1:0];
				req.wdata = rdata;
			end
			S_FACT: begin
				req.we    = jl_q ^ jr_q;
				req.waddr = jl_q ? idx_m1[AW-1:0] : idx_q[AW-1:0];
				req.wdata = jl_q
					? ffra_pkg::entry_t'{start: left_q.start, length: rs.res[LW-1:0]}
					: ffra_pkg::entry_t'{start: off_q, length: rs.res[LW-1:0]};
			end
			S_FJB: begin
				req.we    = 1'b1;
				req.waddr = idx_m1[AW-1:0];
				req.wdata = '{start: left_q.start, length: rs.res[LW-1:0]};
			end
			S_INRD: begin
				req.raddr = k_m1[AW-1:0];
				req.we    = (k_q == idx_q);
				req.waddr = idx_q[AW-1:0];
				req.wdata = '{start: off_q, length: count_q};
			end
			S_INWR: begin
				req.we    = 1'b1;
				req.waddr = k_q[AW-1:0];
				req.wdata = rdata;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			heap_q      <= HEAP_MAX;
			cnt_q       <= IDX_ONE;
			free_q      <= HEAP_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q   <= IDX_ONE;
					free_q  <= heap_q;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_valid) begin
						heap_q  <= cfg_clamp;
						state_q <= S_INIT;
					end else if (in_valid) begin
						kind_q   <= kind;
						count_q  <= count;
						off_q    <= offset;
						blk_q    <= '0;
						status_q <= ffra_pkg::ST_OK;
						if (count == '0) begin
							state_q <= S_DONE;
						end else if (kind == ffra_pkg::KIND_ALLOC) begin
							state_q <= S_ACHK;
						end else begin
							state_q <= S_FEND;
						end
					end
				end
				S_ACHK: begin
					idx_q <= '0;
					if (rs.lt) begin
						status_q <= ffra_pkg::ST_TOTAL;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					if (idx_q == cnt_q) begin
						status_q <= ffra_pkg::ST_FRAG;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ACMP;
					end
				end
				S_ACMP: begin
					if (rs.lt) begin
						idx_q   <= idx_q + IDX_ONE;
						state_q <= S_ARD;
					end else begin
						ent_q   <= rdata;
						tmp_q   <= rs.res[LW-1:0];
						state_q <= S_ABLK;
					end
				end
				S_ABLK: begin
					blk_q <= rs.res[OW-1:0];
					k_q   <= idx_q;
					state_q <= (tmp_q == '0) ? S_ERRD : S_ATOT;
				end
				S_ATOT: begin
					free_q  <= rs.res[LW-1:0];
					state_q <= S_DONE;
				end
				S_ERRD: begin
					if (k_p1 >= cnt_q) begin
						cnt_q   <= cnt_q - IDX_ONE;
						state_q <= (kind_q == ffra_pkg::KIND_ALLOC) ? S_ATOT : S_FTOT;
					end else begin
						state_q <= S_ERWR;
					end
				end
				S_ERWR: begin
					k_q     <= k_p1;
					state_q <= S_ERRD;
				end
				S_FEND: begin
					end_q <= rs.res[LW-1:0];
					// carry out of the end sum means past any heap
					if (rs.res[LW]) begin
						status_q <= ffra_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					idx_q       <= '0;
					has_left_q  <= 1'b0;
					has_right_q <= 1'b0;
					jl_q        <= 1'b0;
					jr_q        <= 1'b0;
					if (rs.lt) begin
						status_q <= ffra_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= (idx_q == cnt_q) ? S_LCHK : S_FCMP;
				end
				S_FCMP: begin
					if (!rs.lt) begin
						left_q     <= rdata;
						has_left_q <= 1'b1;
						idx_q      <= idx_q + IDX_ONE;
						state_q    <= S_FRD;
					end else begin
						right_q     <= rdata;
						has_right_q <= 1'b1;
						state_q     <= S_LCHK;
					end
				end
				S_LCHK: begin
					tmp_q   <= rs.res[LW-1:0];
					state_q <= has_left_q ? S_LCMP : S_RCHK;
				end
				S_LCMP: begin
					if (rs.lt) begin
						status_q <= ffra_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						jl_q    <= rs.eq;
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					if (has_right_q && rs.lt) begin
						status_q <= ffra_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						jr_q    <= has_right_q && rs.eq;
						state_q <= S_FACT;
					end
				end
				S_FACT: begin
					k_q <= cnt_q;
					if (jl_q && jr_q) begin
						tmp_q   <= rs.res[LW-1:0];
						state_q <= S_FJB;
					end else if (jl_q || jr_q) begin
						state_q <= S_FTOT;
					end else if (cnt_q == IDX_MAX) begin
						status_q <= ffra_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_INRD;
					end
				end
				S_FJB: begin
					k_q     <= idx_q;
					state_q <= S_ERRD;
				end
				S_INRD: begin
					if (k_q == idx_q) begin
						cnt_q   <= cnt_q + IDX_ONE;
						state_q <= S_FTOT;
					end else begin
						state_q <= S_INWR;
					end
				end
				S_INWR: begin
					k_q     <= k_m1;
					state_q <= S_INRD;
				end
				S_FTOT: begin
					free_q  <= rs.res[LW-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						o_status_q  <= status_q;
						o_blk_q     <= (status_q == ffra_pkg::ST_OK) ? blk_q : '0;
						o_free_q    <= free_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	`FFRA_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_q <= IDX_MAX)
	`FFRA_ASSERT_NOW(a_free_le_heap, state_q == S_IDLE, free_q <= heap_q)
	`FFRA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE)
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for first_fit_range_allocator: allocate/free words
// checked against an in-bench free-range table predictor.
// Depends on ffra_pkg and the first_fit_range_allocator RTL.
`timescale 1ns / 100ps
module tb_top;
	localparam int PLAN = 0;	// state used while building stimulus
	localparam int CHK  = 1;	// state advanced on accepted words
	localparam int IDLE_LIMIT = 50000;

	typedef struct {
		logic        k;
		logic [10:0] c;
		logic [9:0]  o;
	} req_t;

	typedef struct {
		logic [1:0]  st;
		logic [9:0]  blk;
		logic [10:0] tot;
	} resp_t;

	typedef struct {
		int o;
		int c;
	} live_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = ffra_pkg::KIND_ALLOC;
	logic [10:0] count = '0;
	logic [9:0]  offset = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [9:0]  block_offset;
	logic [10:0] free_total;

	// free-range tables, one per state copy
	logic [9:0]  rng_start[2][ffra_pkg::MAX_RANGES];
	logic [10:0] rng_len[2][ffra_pkg::MAX_RANGES];
	int          rng_cnt[2];
	int          free_cnt[2];
	int          heap_sz[2];

	req_t  pend_q[$];
	resp_t resp_q[$];
	live_t live_q[$];
	int    errs = 0;

	first_fit_range_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .count(count), .offset(offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_offset(block_offset), .free_total(free_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void heap_init(int s, int v);
		if (v == 0)
			v = 1;
		if (v > ffra_pkg::MAX_SLOTS)
			v = ffra_pkg::MAX_SLOTS;
		heap_sz[s] = v;
		rng_start[s][0] = '0;
		rng_len[s][0] = 11'(v);
		rng_cnt[s] = 1;
		free_cnt[s] = v;
	endfunction

	function automatic void range_erase(int s, int i);
		for (int k = i; k + 1 < rng_cnt[s]; k++) begin
			rng_start[s][k] = rng_start[s][k+1];
			rng_len[s][k] = rng_len[s][k+1];
		end
		rng_cnt[s]--;
	endfunction

	function automatic void range_insert(int s, int i, int st, int len);
		for (int k = rng_cnt[s]; k > i; k--) begin
			rng_start[s][k] = rng_start[s][k-1];
			rng_len[s][k] = rng_len[s][k-1];
		end
		rng_start[s][i] = 10'(st);
		rng_len[s][i] = 11'(len);
		rng_cnt[s]++;
	endfunction

	// Apply one request to table s; returns status, block start via blk.
	function automatic logic [1:0] alloc_free_step(int s, logic k, int cnt, int off,
			output int blk);
		int r, e, rest, lend;
		bit hl, hr, jl, jr;
		blk = 0;
		if (cnt == 0)
			return ffra_pkg::ST_OK;
		if (k == ffra_pkg::KIND_ALLOC) begin
			if (cnt > free_cnt[s])
				return ffra_pkg::ST_TOTAL;
			for (int i = 0; i < rng_cnt[s]; i++) begin
				if (int'(rng_len[s][i]) >= cnt) begin
					rest = int'(rng_len[s][i]) - cnt;
					blk = int'(rng_start[s][i]) + rest;
					if (rest == 0)
						range_erase(s, i);
					else
						rng_len[s][i] = 11'(rest);
					free_cnt[s] -= cnt;
					return ffra_pkg::ST_OK;
				end
			end
			return ffra_pkg::ST_FRAG;
		end
		e = off + cnt;
		if (e > heap_sz[s])
			return ffra_pkg::ST_BAD;
		r = 0;
		while (r < rng_cnt[s] && int'(rng_start[s][r]) <= off)
			r++;
		hl = r > 0;
		hr = r < rng_cnt[s];
		lend = hl ? int'(rng_start[s][r-1]) + int'(rng_len[s][r-1]) : 0;
		if (hl && lend > off)
			return ffra_pkg::ST_BAD;
		if (hr && e > int'(rng_start[s][r]))
			return ffra_pkg::ST_BAD;
		jl = hl && lend == off;
		jr = hr && e == int'(rng_start[s][r]);
		if (jl) begin
			rng_len[s][r-1] = 11'(int'(rng_len[s][r-1]) + cnt);
			if (jr) begin
				rng_len[s][r-1] = 11'(int'(rng_len[s][r-1]) + int'(rng_len[s][r]));
				range_erase(s, r);
			end
		end else if (jr) begin
			rng_len[s][r] = 11'(int'(rng_len[s][r]) + cnt);
			rng_start[s][r] = 10'(off);
		end else begin
			if (rng_cnt[s] >= ffra_pkg::MAX_RANGES)
				return ffra_pkg::ST_BAD;
			range_insert(s, r, off, cnt);
		end
		free_cnt[s] += cnt;
		return ffra_pkg::ST_OK;
	endfunction

	// Queue a word and track the blocks it leaves allocated.
	function automatic void plan_push(logic k, int c, int o);
		req_t  rq;
		live_t lb;
		int    blk;
		logic [1:0] st;
		rq.k = k;
		rq.c = 11'(c);
		rq.o = 10'(o);
		pend_q.push_back(rq);
		st = alloc_free_step(PLAN, k, c, o, blk);
		if (k == ffra_pkg::KIND_ALLOC && st == ffra_pkg::ST_OK && c != 0) begin
			lb.o = blk;
			lb.c = c;
			live_q.push_back(lb);
		end
	endfunction

	// Mostly well-formed traffic: frees return live blocks or pieces of them.
	function automatic void plan_random(int n);
		int h, sel, idx, p;
		live_t lb;
		h = heap_sz[PLAN];
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				p = $urandom_range(0, 99);
				if (p < 4)
					plan_push(ffra_pkg::KIND_ALLOC, 0, $urandom_range(0, 1023));
				else if (p < 10)
					plan_push(ffra_pkg::KIND_ALLOC, $urandom_range(0, 2047),
						$urandom_range(0, 1023));
				else if (p < 22)
					plan_push(ffra_pkg::KIND_ALLOC, $urandom_range(1, h),
						$urandom_range(0, 1023));
				else
					plan_push(ffra_pkg::KIND_ALLOC, $urandom_range(1, (h < 16) ? 1 : h / 8),
						$urandom_range(0, 1023));
			end else if (sel < 88 && live_q.size() != 0) begin
				idx = $urandom_range(0, live_q.size() - 1);
				lb = live_q[idx];
				if ($urandom_range(0, 1) || lb.c == 1) begin
					live_q.delete(idx);
					plan_push(!ffra_pkg::KIND_ALLOC, lb.c, lb.o);
				end else begin
					p = $urandom_range(1, lb.c - 1);
					if ($urandom_range(0, 1)) begin
						live_q[idx].o = lb.o + p;
						live_q[idx].c = lb.c - p;
						plan_push(!ffra_pkg::KIND_ALLOC, p, lb.o);
					end else begin
						live_q[idx].c = lb.c - p;
						plan_push(!ffra_pkg::KIND_ALLOC, p, lb.o + lb.c - p);
					end
				end
			end else begin
				// noise: arbitrary frees, mostly rejected
				if ($urandom_range(0, 1))
					plan_push(!ffra_pkg::KIND_ALLOC, $urandom_range(0, 2047),
						$urandom_range(0, 1023));
				else
					plan_push(!ffra_pkg::KIND_ALLOC, $urandom_range(0, 64),
						$urandom_range(0, 1023));
			end
		end
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		req_t  rq;
		resp_t ex;
		int    blk;
		logic  nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				ex.st = alloc_free_step(CHK, kind, count, offset, blk);
				ex.blk = (ex.st == ffra_pkg::ST_OK) ? blk[9:0] : '0;
				ex.tot = 11'(free_cnt[CHK]);
				resp_q.push_back(ex);
			end
			if (!in_valid || in_ready) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pend_q.size() != 0) begin
					rq = pend_q.pop_front();
					kind <= rq.k;
					count <= rq.c;
					offset <= rq.o;
					nv = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
				in_valid <= nv;
			end
		end
	end

	// receiver: stall pattern steps through four modes, plus two long hold-offs
	int rx_cyc = 0;
	int rx_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cyc <= 0;
			rx_hold <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				out_ready <= 1'b0;
			end else if (rx_cyc == 3000 || rx_cyc == 40000) begin
				rx_hold <= 400;
				out_ready <= 1'b0;
			end else begin
				case (rx_cyc[8:7])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= 1'($urandom_range(0, 1));
					2'd2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		resp_t ex;
		if (arst_n && out_valid && out_ready) begin
			if (resp_q.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("unexpected result word: st=%0d blk=%0d tot=%0d",
						status, block_offset, free_total);
			end else begin
				ex = resp_q.pop_front();
				if (status !== ex.st || block_offset !== ex.blk || free_total !== ex.tot) begin
					errs++;
					if (errs <= 10)
						$display("mismatch: exp st=%0d blk=%0d tot=%0d, got st=%0d blk=%0d tot=%0d",
							ex.st, ex.blk, ex.tot, status, block_offset, free_total);
				end
			end
		end
	end

	// watchdog on cycles with no word moving on any channel
	int idle_cyc = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic drain();
		while (pend_q.size() != 0 || in_valid || resp_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic heap_write(int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 11'(v);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		heap_init(CHK, v);
		heap_init(PLAN, v);
		live_q.delete();
	endtask

	int heap_list[10] = '{1024, 0, 64, 2047, 1, 300, 17, 1024, 500, 130};

	initial begin
		heap_init(PLAN, ffra_pkg::MAX_SLOTS);
		heap_init(CHK, ffra_pkg::MAX_SLOTS);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero counts, overflow, full heap, merges, rejects, fragmentation
		plan_push(ffra_pkg::KIND_ALLOC, 0, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 0, 1023);
		plan_push(ffra_pkg::KIND_ALLOC, 2047, 0);
		plan_push(ffra_pkg::KIND_ALLOC, 1024, 0);
		plan_push(ffra_pkg::KIND_ALLOC, 1, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 1, 1023);
		plan_push(ffra_pkg::KIND_ALLOC, 1, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 100, 1000);
		plan_push(!ffra_pkg::KIND_ALLOC, 512, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 100, 512);
		plan_push(!ffra_pkg::KIND_ALLOC, 10, 700);
		plan_push(!ffra_pkg::KIND_ALLOC, 10, 600);
		plan_push(ffra_pkg::KIND_ALLOC, 700, 0);
		plan_push(ffra_pkg::KIND_ALLOC, 620, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 88, 612);
		plan_push(ffra_pkg::KIND_ALLOC, 10, 0);
		plan_push(!ffra_pkg::KIND_ALLOC, 5, 705);
		plan_push(!ffra_pkg::KIND_ALLOC, 5, 700);
		plan_push(!ffra_pkg::KIND_ALLOC, 2047, 1023);
		plan_push(ffra_pkg::KIND_ALLOC, 300, 1023);

		foreach (heap_list[i]) begin
			drain();
			heap_write(heap_list[i]);
			plan_random(193);
		end
		drain();
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
